/* rtl/gray_framebuffer_dirty_tracker_defines.svh */
// Assertion macros for the gray framebuffer dirty tracker.
`ifndef GRAY_FRAMEBUFFER_DIRTY_TRACKER_DEFINES_SVH
`define GRAY_FRAMEBUFFER_DIRTY_TRACKER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on clk, off during reset
`define GFDT_ASSERT_IMP(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("gfdt assertion failed: same-cycle implication");
// next-cycle implication, sampled on clk, off during reset
`define GFDT_ASSERT_NXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("gfdt assertion failed: next-cycle implication");
`else
`define GFDT_ASSERT_IMP(name, pre, post)
`define GFDT_ASSERT_NXT(name, pre, post)
`endif
`endif

/* rtl/gfdt_pkg.sv */
// Shared constants, types and op codes of the gray framebuffer dirty tracker.
`timescale 1ns / 1ps
package gfdt_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	// fixed field widths
	localparam int CMD_W  = 2;
	localparam int PIX_W  = 10;
	localparam int SRC_W  = 8;
	localparam int GRAY_W = 4;
	localparam int DIM_W  = 11;
	localparam int CNT_W  = 11;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// command codes
	localparam logic [CMD_W-1:0] CMD_DRAW   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_COMMIT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

	// config register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_PANEL_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PANEL_HEIGHT = 2'd1;
	localparam logic [DIM_W-1:0] PANEL_WIDTH_RST  = 11'd960;
	localparam logic [DIM_W-1:0] PANEL_HEIGHT_RST = 11'd540;

	// classified op kinds
	localparam int OP_W = 3;
	localparam logic [OP_W-1:0] OP_NOP    = 3'd0;
	localparam logic [OP_W-1:0] OP_DRAW   = 3'd1;
	localparam logic [OP_W-1:0] OP_FAIL   = 3'd2;
	localparam logic [OP_W-1:0] OP_COMMIT = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

	// gray store: 16 pixels (8 bytes) per word, fixed row pitch
	localparam int G_PIX      = 16;
	localparam int G_WORD_W   = G_PIX * GRAY_W;
	localparam int G_SEL_W    = $clog2(G_PIX);
	localparam int G_ROW_WORDS = (MAX_WIDTH + G_PIX - 1) / G_PIX;
	localparam int G_DEPTH    = G_ROW_WORDS * MAX_HEIGHT;
	localparam int G_AW       = (G_DEPTH > 1) ? $clog2(G_DEPTH) : 1;

	// dirty marks: 64 pixels per word
	localparam int M_PIX      = 64;
	localparam int M_SEL_W    = $clog2(M_PIX);
	localparam int M_ROW_WORDS = (MAX_WIDTH + M_PIX - 1) / M_PIX;
	localparam int M_DEPTH    = M_ROW_WORDS * MAX_HEIGHT;
	localparam int M_AW       = (M_DEPTH > 1) ? $clog2(M_DEPTH) : 1;

	// row counts
	localparam int R_AW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

	// queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

	typedef logic [G_AW-1:0]    gaddr_t;
	typedef logic [M_AW-1:0]    maddr_t;
	typedef logic [R_AW-1:0]    raddr_t;
	typedef logic [G_SEL_W-1:0] gsel_t;
	typedef logic [M_SEL_W-1:0] msel_t;
	typedef logic [Q_AW-1:0]    qptr_t;
	typedef logic [Q_AW:0]      qcnt_t;

	// sweep end points, all within the gray address range
	localparam gaddr_t G_LAST = gaddr_t'(G_DEPTH - 1);
	localparam gaddr_t M_LAST = gaddr_t'(M_DEPTH - 1);
	localparam gaddr_t R_LAST = gaddr_t'(MAX_HEIGHT - 1);

	typedef struct packed {
		logic [OP_W-1:0]   kind;
		logic [GRAY_W-1:0] gray;
		gaddr_t            gaddr;
		gsel_t             gsel;
		maddr_t            maddr;
		msel_t             msel;
		raddr_t            row;
	} op_t;

	typedef struct packed {
		logic valid;
		logic full;
	} q_stat_t;

endpackage

/* rtl/gray_framebuffer_dirty_tracker.sv */
// Top level of the 4bpp gray framebuffer with per-pixel dirty marks and per-row counts.
// Items enter on in_valid/in_stall and results leave on out_valid/out_stall, one
// result per item, in order. The front end classifies each item (draw, failed draw,
// commit, clear, unused code) and queues it; the back end executes one op at a time.
// A draw is a read-modify-write of three RAMs (gray words of 16 pixels, mark words
// of 64 pixels, row counts): the read is issued when the op is taken, and the update
// and result load follow in the next cycle. Failed draws and unused codes load their
// result when taken. A commit loads its result when taken and then sweeps the mark
// and count RAMs one word per cycle, over all 16384 mark words whatever the panel
// registers hold; a clear also sweeps the gray RAM, 65536 words. After reset the
// same clearing pass as a clear runs with in_stall held high; config writes are taken
// at any time. The result register lets a new item enter while a finished result
// still waits to be taken.
`timescale 1ns / 1ps
module gray_framebuffer_dirty_tracker (
	input  logic                               clk,
	input  logic                               arst_n,
	// item input
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [gfdt_pkg::CMD_W-1:0]         cmd,
	input  logic [gfdt_pkg::PIX_W-1:0]         pixel_x,
	input  logic [gfdt_pkg::PIX_W-1:0]         pixel_y,
	input  logic [gfdt_pkg::SRC_W-1:0]         source_gray,
	// result output
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               status,
	output logic                               changed,
	output logic [gfdt_pkg::GRAY_W-1:0]        previous_gray,
	output logic [gfdt_pkg::CNT_W-1:0]         row_dirty_count,
	// config write port
	input  logic                               cfg_we,
	input  logic [gfdt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gfdt_pkg::DIM_W-1:0]         cfg_data
);

	logic [gfdt_pkg::DIM_W-1:0] panel_width_q;
	logic [gfdt_pkg::DIM_W-1:0] panel_height_q;

	logic              push;
	gfdt_pkg::op_t     push_op;
	logic              pop;
	gfdt_pkg::q_stat_t q_stat;
	gfdt_pkg::op_t     q_op;
	logic              init_busy;

	// panel size registers; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			panel_width_q  <= gfdt_pkg::PANEL_WIDTH_RST;
			panel_height_q <= gfdt_pkg::PANEL_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				gfdt_pkg::REG_PANEL_WIDTH: begin
					panel_width_q <= cfg_data;
				end
				gfdt_pkg::REG_PANEL_HEIGHT: begin
					panel_height_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// classify and address items as they arrive
	gfdt_front u_front (
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.source_gray  (source_gray),
		.panel_width  (panel_width_q),
		.panel_height (panel_height_q),
		.q_stat       (q_stat),
		.init_busy    (init_busy),
		.push         (push),
		.push_op      (push_op)
	);

	// decouples acceptance from execution so each side stalls on its own
	gfdt_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.q_stat  (q_stat),
		.q_op    (q_op)
	);

	// store access, sweeps and result register
	gfdt_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_stat          (q_stat),
		.q_op            (q_op),
		.pop             (pop),
		.init_busy       (init_busy),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.changed         (changed),
		.previous_gray   (previous_gray),
		.row_dirty_count (row_dirty_count)
	);

endmodule

/* rtl/gfdt_ram.sv */
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module gfdt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/gfdt_front.sv */
// Front end: accepts items, range-checks draws and builds store addresses.
`timescale 1ns / 1ps
module gfdt_front (
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [gfdt_pkg::CMD_W-1:0]       cmd,
	input  logic [gfdt_pkg::PIX_W-1:0]       pixel_x,
	input  logic [gfdt_pkg::PIX_W-1:0]       pixel_y,
	input  logic [gfdt_pkg::SRC_W-1:0]       source_gray,
	input  logic [gfdt_pkg::DIM_W-1:0]       panel_width,
	input  logic [gfdt_pkg::DIM_W-1:0]       panel_height,
	input  gfdt_pkg::q_stat_t                q_stat,
	input  logic                             init_busy,
	output logic                             push,
	output gfdt_pkg::op_t                    push_op
);

	logic           x_ok;
	logic           y_ok;
	gfdt_pkg::raddr_t row;

	// effective size is min(register, max) -> both compares must pass
	assign x_ok = ({1'b0, pixel_x} < panel_width) &&
		(32'(pixel_x) < 32'(gfdt_pkg::MAX_WIDTH));
	assign y_ok = ({1'b0, pixel_y} < panel_height) &&
		(32'(pixel_y) < 32'(gfdt_pkg::MAX_HEIGHT));

	assign row = gfdt_pkg::raddr_t'(pixel_y);

	assign in_stall = q_stat.full || init_busy;
	assign push     = in_valid && !in_stall;

	always_comb begin
		push_op.gray  = source_gray[gfdt_pkg::SRC_W-1 -: gfdt_pkg::GRAY_W];
		push_op.row   = row;
		push_op.gaddr = gfdt_pkg::gaddr_t'(
			gfdt_pkg::gaddr_t'(row) * gfdt_pkg::gaddr_t'(gfdt_pkg::G_ROW_WORDS) +
			gfdt_pkg::gaddr_t'(pixel_x[gfdt_pkg::PIX_W-1:gfdt_pkg::G_SEL_W]));
		push_op.gsel  = pixel_x[gfdt_pkg::G_SEL_W-1:0];
		push_op.maddr = gfdt_pkg::maddr_t'(
			gfdt_pkg::maddr_t'(row) * gfdt_pkg::maddr_t'(gfdt_pkg::M_ROW_WORDS) +
			gfdt_pkg::maddr_t'(pixel_x[gfdt_pkg::PIX_W-1:gfdt_pkg::M_SEL_W]));
		push_op.msel  = pixel_x[gfdt_pkg::M_SEL_W-1:0];
		case (cmd)
			gfdt_pkg::CMD_DRAW: begin
				push_op.kind = (x_ok && y_ok) ? gfdt_pkg::OP_DRAW : gfdt_pkg::OP_FAIL;
			end
			gfdt_pkg::CMD_COMMIT: begin
				push_op.kind = gfdt_pkg::OP_COMMIT;
			end
			gfdt_pkg::CMD_CLEAR: begin
				push_op.kind = gfdt_pkg::OP_CLEAR;
			end
			default: begin
				push_op.kind = gfdt_pkg::OP_NOP;
			end
		endcase
	end

endmodule

/* rtl/gfdt_queue.sv */
// Short op queue between the front end and the back end.
`timescale 1ns / 1ps
module gfdt_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  gfdt_pkg::op_t     push_op,
	input  logic              pop,
	output gfdt_pkg::q_stat_t q_stat,
	output gfdt_pkg::op_t     q_op
);

	gfdt_pkg::op_t   ent_q [gfdt_pkg::Q_DEPTH];
	gfdt_pkg::qptr_t wr_ptr_q;
	gfdt_pkg::qptr_t rd_ptr_q;
	gfdt_pkg::qcnt_t cnt_q;

	localparam gfdt_pkg::qptr_t PTR_LAST = gfdt_pkg::qptr_t'(gfdt_pkg::Q_DEPTH - 1);
	localparam gfdt_pkg::qcnt_t CNT_FULL = gfdt_pkg::qcnt_t'(gfdt_pkg::Q_DEPTH);

	assign q_stat.valid = (cnt_q != '0);
	assign q_stat.full  = (cnt_q == CNT_FULL);
	assign q_op         = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

/* rtl/gfdt_back.sv */
// Back end: pixel read-modify-write, store sweeps and the result register.
`timescale 1ns / 1ps
`include "gray_framebuffer_dirty_tracker_defines.svh"
module gfdt_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  gfdt_pkg::q_stat_t           q_stat,
	input  gfdt_pkg::op_t               q_op,
	output logic                        pop,
	output logic                        init_busy,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        status,
	output logic                        changed,
	output logic [gfdt_pkg::GRAY_W-1:0] previous_gray,
	output logic [gfdt_pkg::CNT_W-1:0]  row_dirty_count
);

	localparam logic [1:0] ST_SWEEP = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_MOD   = 2'd2;

	logic [1:0]        state_q;
	gfdt_pkg::gaddr_t  sweep_cnt_q;
	logic              sweep_gray_q;
	logic              init_q;
	logic              out_valid_q;
	gfdt_pkg::op_t     op_s1;

	gfdt_pkg::gaddr_t  sweep_last;
	logic              rd_en;
	logic              load_res;

	logic                               g_we;
	gfdt_pkg::gaddr_t                   g_waddr;
	logic [gfdt_pkg::G_WORD_W-1:0]      g_wdata;
	logic [gfdt_pkg::G_WORD_W-1:0]      g_rd;
	logic [gfdt_pkg::G_WORD_W-1:0]      g_new;
	logic                               m_we;
	gfdt_pkg::maddr_t                   m_waddr;
	logic [gfdt_pkg::M_PIX-1:0]         m_wdata;
	logic [gfdt_pkg::M_PIX-1:0]         m_rd;
	logic [gfdt_pkg::M_PIX-1:0]         m_new;
	logic                               r_we;
	gfdt_pkg::raddr_t                   r_waddr;
	logic [gfdt_pkg::CNT_W-1:0]         r_wdata;
	logic [gfdt_pkg::CNT_W-1:0]         r_rd;

	logic [gfdt_pkg::GRAY_W-1:0] cur_gray;
	logic                        chg;
	logic                        new_mark;
	logic [gfdt_pkg::CNT_W-1:0]  cnt_next;
	logic [gfdt_pkg::G_SEL_W+1:0] nib_off;

	logic                        res_status;
	logic                        res_changed;
	logic [gfdt_pkg::GRAY_W-1:0] res_prev;
	logic [gfdt_pkg::CNT_W-1:0]  res_count;

	// take a new op only when the result slot is free by the time it is loaded
	assign pop = (state_q == ST_IDLE) && q_stat.valid && (!out_valid_q || !out_stall);
	assign rd_en = pop && (q_op.kind == gfdt_pkg::OP_DRAW);
	assign load_res = (pop && (q_op.kind != gfdt_pkg::OP_DRAW)) || (state_q == ST_MOD);
	assign sweep_last = sweep_gray_q ? gfdt_pkg::G_LAST : gfdt_pkg::M_LAST;
	assign init_busy = init_q;
	assign out_valid = out_valid_q;

	// even pixel in the high nibble of its byte
	assign nib_off = {op_s1.gsel[gfdt_pkg::G_SEL_W-1:1], ~op_s1.gsel[0], 2'b00};
	assign cur_gray = g_rd[nib_off +: gfdt_pkg::GRAY_W];
	assign chg = (cur_gray != op_s1.gray);
	assign new_mark = chg && !m_rd[op_s1.msel];
	assign cnt_next = (new_mark && (r_rd != gfdt_pkg::CNT_MAX)) ? r_rd + 1'b1 : r_rd;

	always_comb begin
		g_new = g_rd;
		g_new[nib_off +: gfdt_pkg::GRAY_W] = op_s1.gray;
		m_new = m_rd;
		m_new[op_s1.msel] = 1'b1;
	end

	always_comb begin
		g_we    = 1'b0;
		g_waddr = op_s1.gaddr;
		g_wdata = g_new;
		m_we    = 1'b0;
		m_waddr = op_s1.maddr;
		m_wdata = m_new;
		r_we    = 1'b0;
		r_waddr = op_s1.row;
		r_wdata = cnt_next;
		case (state_q)
			ST_SWEEP: begin
				g_we    = sweep_gray_q;
				g_waddr = sweep_cnt_q;
				g_wdata = '1;
				m_we    = (sweep_cnt_q <= gfdt_pkg::M_LAST);
				m_waddr = sweep_cnt_q[gfdt_pkg::M_AW-1:0];
				m_wdata = '0;
				r_we    = (sweep_cnt_q <= gfdt_pkg::R_LAST);
				r_waddr = sweep_cnt_q[gfdt_pkg::R_AW-1:0];
				r_wdata = '0;
			end
			ST_MOD: begin
				g_we = chg;
				m_we = new_mark;
				r_we = new_mark;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		res_status  = 1'b0;
		res_changed = 1'b0;
		res_prev    = '0;
		res_count   = '0;
		if (state_q == ST_MOD) begin
			res_changed = chg;
			res_prev    = cur_gray;
			res_count   = cnt_next;
		end else if (q_op.kind == gfdt_pkg::OP_FAIL) begin
			res_status = 1'b1;
		end
	end

	gfdt_ram #(.WIDTH(gfdt_pkg::G_WORD_W), .DEPTH(gfdt_pkg::G_DEPTH)) u_gray_ram (
		.clk   (clk),
		.we    (g_we),
		.waddr (g_waddr),
		.wdata (g_wdata),
		.re    (rd_en),
		.raddr (q_op.gaddr),
		.rdata (g_rd)
	);

	gfdt_ram #(.WIDTH(gfdt_pkg::M_PIX), .DEPTH(gfdt_pkg::M_DEPTH)) u_mark_ram (
		.clk   (clk),
		.we    (m_we),
		.waddr (m_waddr),
		.wdata (m_wdata),
		.re    (rd_en),
		.raddr (q_op.maddr),
		.rdata (m_rd)
	);

	gfdt_ram #(.WIDTH(gfdt_pkg::CNT_W), .DEPTH(gfdt_pkg::MAX_HEIGHT)) u_count_ram (
		.clk   (clk),
		.we    (r_we),
		.waddr (r_waddr),
		.wdata (r_wdata),
		.re    (rd_en),
		.raddr (q_op.row),
		.rdata (r_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_SWEEP;
			sweep_cnt_q  <= '0;
			sweep_gray_q <= 1'b1;
			init_q       <= 1'b1;
			out_valid_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_SWEEP: begin
					if (sweep_cnt_q == sweep_last) begin
						state_q     <= ST_IDLE;
						init_q      <= 1'b0;
						sweep_cnt_q <= '0;
					end else begin
						sweep_cnt_q <= sweep_cnt_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (pop) begin
						case (q_op.kind)
							gfdt_pkg::OP_DRAW: begin
								state_q <= ST_MOD;
							end
							gfdt_pkg::OP_COMMIT: begin
								state_q      <= ST_SWEEP;
								sweep_gray_q <= 1'b0;
								sweep_cnt_q  <= '0;
							end
							gfdt_pkg::OP_CLEAR: begin
								state_q      <= ST_SWEEP;
								sweep_gray_q <= 1'b1;
								sweep_cnt_q  <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_MOD: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (load_res) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_s1 <= q_op;
		end
		if (load_res) begin
			status          <= res_status;
			changed         <= res_changed;
			previous_gray   <= res_prev;
			row_dirty_count <= res_count;
		end
	end

	`GFDT_ASSERT_IMP(a_mod_slot_free, state_q == ST_MOD, !out_valid_q)
	`GFDT_ASSERT_NXT(a_mod_gives_result, state_q == ST_MOD, out_valid_q)
	`GFDT_ASSERT_IMP(a_no_pop_in_init, init_q, !pop)
	`GFDT_ASSERT_IMP(a_sweep_in_range, state_q == ST_SWEEP, sweep_cnt_q <= sweep_last)

endmodule
